>>> design/fbp_pkg.sv
package fbp_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam int MAX_PAYLOAD_DEFAULT = 1024;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_CMD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_FIX_EN = 8'd3;

    localparam logic [BYTE_W-1:0] HEAD_BYTE_RST  = 8'd126;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RST  = 8'd127;
    localparam logic [BYTE_W-1:0] MODULE_CMD_RST = 8'd80;
    localparam logic              LEN_FIX_EN_RST = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] head_byte;
        logic [BYTE_W-1:0] tail_byte;
        logic [BYTE_W-1:0] module_cmd;
        logic              len_fix_enable;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   cmd_id;
        logic [BYTE_W-1:0]   seq_id;
        logic [LEN_W-1:0]    payload_len;
    } t_res;

endpackage

>>> design/fbp_byte_if.sv
interface fbp_byte_if;
    logic                      valid;
    logic                      ready;
    logic [fbp_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

>>> design/fbp_res_if.sv
interface fbp_res_if;
    logic                         valid;
    logic                         ready;
    logic [fbp_pkg::STATUS_W-1:0] status;
    logic                         payload_valid;
    logic [fbp_pkg::BYTE_W-1:0]   payload_byte;
    logic [fbp_pkg::BYTE_W-1:0]   cmd_id;
    logic [fbp_pkg::BYTE_W-1:0]   seq_id;
    logic [fbp_pkg::LEN_W-1:0]    payload_len;

    modport source (output valid, output status, output payload_valid, output payload_byte,
                    output cmd_id, output seq_id, output payload_len, input ready);
    modport sink   (input valid, input status, input payload_valid, input payload_byte,
                    input cmd_id, input seq_id, input payload_len, output ready);
endinterface

>>> design/fbp_cfg_if.sv
interface fbp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fbp_pkg::CFG_IDX_W-1:0] index;
    logic [fbp_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/fbp_cfg_regs.sv
module fbp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [fbp_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [fbp_pkg::CFG_DAT_W-1:0] i_data,
    output fbp_pkg::t_cfg                 o_cfg
);

    fbp_pkg::t_cfg r_cfg;
    fbp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                fbp_pkg::CFG_HEAD_BYTE:  n_cfg.head_byte      = i_data;
                fbp_pkg::CFG_TAIL_BYTE:  n_cfg.tail_byte      = i_data;
                fbp_pkg::CFG_MODULE_CMD: n_cfg.module_cmd     = i_data;
                fbp_pkg::CFG_LEN_FIX_EN: n_cfg.len_fix_enable = i_data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte      <= fbp_pkg::HEAD_BYTE_RST;
            r_cfg.tail_byte      <= fbp_pkg::TAIL_BYTE_RST;
            r_cfg.module_cmd     <= fbp_pkg::MODULE_CMD_RST;
            r_cfg.len_fix_enable <= fbp_pkg::LEN_FIX_EN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/fbp_parser.sv
module fbp_parser #(
    parameter int MAX_PAYLOAD = fbp_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [fbp_pkg::BYTE_W-1:0] i_byte,
    input  fbp_pkg::t_cfg              i_cfg,
    output fbp_pkg::t_res              o_res
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_CMD    = 3'd1;
    localparam logic [2:0] PH_SEQ    = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_CHECK  = 3'd6;
    localparam logic [2:0] PH_TAIL   = 3'd7;

    localparam logic [fbp_pkg::STATUS_W-1:0] ST_CONTINUE = 2'd0;
    localparam logic [fbp_pkg::STATUS_W-1:0] ST_FRAME    = 2'd1;
    localparam logic [fbp_pkg::STATUS_W-1:0] ST_ERROR    = 2'd2;

    localparam logic [fbp_pkg::LEN_W-1:0] RAW_BAD_LEN = 16'h6202;
    localparam logic [fbp_pkg::LEN_W-1:0] FIXED_LEN   = 16'h0061;
    localparam logic [fbp_pkg::LEN_W-1:0] MAX_LEN     = fbp_pkg::LEN_W'(MAX_PAYLOAD);

    logic [2:0]                 r_phase, n_phase;
    logic [fbp_pkg::BYTE_W-1:0] r_cmd, n_cmd;
    logic [fbp_pkg::BYTE_W-1:0] r_seq, n_seq;
    logic [fbp_pkg::LEN_W-1:0]  r_len, n_len;
    logic [fbp_pkg::LEN_W-1:0]  r_count, n_count;
    logic [fbp_pkg::BYTE_W-1:0] r_xor, n_xor;

    logic [fbp_pkg::LEN_W-1:0]  raw_len;
    logic [fbp_pkg::LEN_W-1:0]  fixed_len;
    logic [fbp_pkg::LEN_W-1:0]  count_inc;

    assign raw_len   = {r_len[7:0], i_byte};
    assign fixed_len = (i_cfg.len_fix_enable && r_cmd == i_cfg.module_cmd
                        && raw_len == RAW_BAD_LEN) ? FIXED_LEN : raw_len;
    assign count_inc = r_count + 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_seq   = r_seq;
        n_len   = r_len;
        n_count = r_count;
        n_xor   = r_xor;
        o_res.status        = ST_CONTINUE;
        o_res.payload_valid = 1'b0;
        o_res.payload_byte  = '0;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.head_byte) n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_xor   = i_byte;
                n_phase = PH_SEQ;
            end
            PH_SEQ: begin
                n_seq   = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {8'd0, i_byte};
                n_xor   = r_xor ^ i_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = fixed_len;
                n_xor   = r_xor ^ i_byte;
                n_count = '0;
                if (fixed_len > MAX_LEN) begin
                    o_res.status = ST_ERROR;
                    n_phase      = PH_HUNT;
                end else if (fixed_len != '0) begin
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_CHECK;  // empty payload: check byte follows
                end
            end
            PH_DATA: begin
                o_res.payload_valid = 1'b1;
                o_res.payload_byte  = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_count = count_inc;
                if (count_inc >= r_len) n_phase = PH_CHECK;
            end
            PH_CHECK: begin
                if (r_xor == i_byte) begin
                    n_phase = PH_TAIL;
                end else begin
                    o_res.status = ST_ERROR;
                    n_phase      = PH_HUNT;
                end
            end
            PH_TAIL: begin
                o_res.status = (i_byte == i_cfg.tail_byte) ? ST_FRAME : ST_ERROR;
                n_phase      = PH_HUNT;
            end
            default: n_phase = PH_HUNT;
        endcase
        o_res.cmd_id      = n_cmd;
        o_res.seq_id      = n_seq;
        o_res.payload_len = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cmd   <= '0;
            r_seq   <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_xor   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_seq   <= n_seq;
            r_len   <= n_len;
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

endmodule

>>> design/framing_byte_parser_xor.sv
// Byte-serial frame parser: head, cmd, seq, 16-bit length, payload, XOR check, tail.
// A result is offered once its byte has passed the input register, loaded when the byte is
// accepted, and then the result register, loaded once it is empty or being read out.
// Throughput: one byte per cycle, held by the combinational update of the frame state
// between the two registers; stalls only on output back-pressure.
// Reset (i_rst_n low, synchronous): parser hunts for a head byte, frame fields clear to
// zero, registers return to head 126, tail 127, module command 80, length fix on.
module framing_byte_parser_xor #(
    parameter int MAX_PAYLOAD = fbp_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fbp_byte_if.sink      i_in,
    fbp_cfg_if.sink       i_cfg,
    fbp_res_if.source     o_out
);

    fbp_pkg::t_cfg cfg;
    fbp_pkg::t_res step_res;

    logic                       r_in_valid;
    logic [fbp_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_valid;
    fbp_pkg::t_res              r_out;
    logic                       advance;
    logic                       in_take;

    // move the held byte into the result register when that register frees up
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    fbp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    fbp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in_byte <= i_in.in_byte;
        if (advance) r_out <= step_res;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.cmd_id        = r_out.cmd_id;
    assign o_out.seq_id        = r_out.seq_id;
    assign o_out.payload_len   = r_out.payload_len;

endmodule
